// ===== hw/rtl/pcl_pkg.sv =====
package pcl_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 6;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_APPEND   = 3'd0;
    localparam kind_t KIND_INS_HEAD = 3'd1;
    localparam kind_t KIND_INS_POS  = 3'd2;
    localparam kind_t KIND_DEL_HEAD = 3'd3;
    localparam kind_t KIND_DEL_TAIL = 3'd4;
    localparam kind_t KIND_DEL_POS  = 3'd5;
    localparam kind_t KIND_DUMP     = 3'd6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [IDX_W-1:0]         idx;
        logic [IDX_W-1:0]         tail;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/pcl_cell.sv =====
module pcl_cell (
    input  logic                              aclk,
    input  logic [pcl_pkg::IDX_W-1:0]         slot_i,
    input  pcl_pkg::cell_cmd_t                cmd_i,
    input  logic signed [pcl_pkg::DATA_W-1:0] left_i,
    input  logic signed [pcl_pkg::DATA_W-1:0] right_i,
    input  logic signed [pcl_pkg::DATA_W-1:0] head_i,
    output logic signed [pcl_pkg::DATA_W-1:0] data_o
);
    import pcl_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd_i.op)
            CELL_INS: begin
                if (slot_i > cmd_i.idx) begin
                    data_next = left_i;
                end else if (slot_i == cmd_i.idx) begin
                    data_next = cmd_i.value;
                end
            end
            CELL_DEL: begin
                if (slot_i >= cmd_i.idx) begin
                    data_next = right_i;
                end
            end
            CELL_ROT: begin
                // head wraps to the tail cell
                if (slot_i == cmd_i.tail) begin
                    data_next = head_i;
                end else if (slot_i < cmd_i.tail) begin
                    data_next = right_i;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

// ===== hw/rtl/pcl_ctrl.sv =====
module pcl_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  pcl_pkg::kind_t                    kind_i,
    input  logic [pcl_pkg::POS_W-1:0]         position_i,
    input  logic signed [pcl_pkg::DATA_W-1:0] value_i,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [1:0]                        status_o,
    output logic signed [pcl_pkg::DATA_W-1:0] item_o,
    output logic [pcl_pkg::CNT_W-1:0]         length_o,
    output logic                              last_o,
    input  logic signed [pcl_pkg::DATA_W-1:0] head_i,
    output pcl_pkg::cell_cmd_t                cmd_o
);
    import pcl_pkg::*;

    typedef enum logic {
        IDLE,
        DUMP
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         dump_reg;
    logic                     m_valid_reg;
    status_t                  m_status_reg;
    logic signed [DATA_W-1:0] m_item_reg;
    logic [CNT_W-1:0]         m_length_reg;
    logic                     m_last_reg;

    logic             out_free;
    logic             accept;
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] tail;
    logic [POS_W-1:0] pos_m1;
    logic             ins_req;
    logic             del_req;
    logic [IDX_W-1:0] edit_idx;
    status_t          st;
    logic [CNT_W-1:0] count_after;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign tail     = count_reg[IDX_W-1:0] - 1'b1;
    assign pos_m1   = position_i - 1'b1;

    always_comb begin
        st       = ST_OK;
        ins_req  = 1'b0;
        del_req  = 1'b0;
        edit_idx = '0;
        case (kind_i)
            KIND_APPEND: begin
                ins_req  = 1'b1;
                edit_idx = count_reg[IDX_W-1:0];
            end
            KIND_INS_HEAD: begin
                ins_req = 1'b1;
            end
            KIND_INS_POS: begin
                if (empty || ({1'b0, position_i} == ({1'b0, count_reg} + 1'b1))) begin
                    ins_req  = 1'b1;
                    edit_idx = count_reg[IDX_W-1:0];
                end else if (position_i == POS_W'(1)) begin
                    ins_req = 1'b1;
                end else if (position_i == '0 || position_i > count_reg) begin
                    st = ST_BADPOS;
                end else begin
                    ins_req  = 1'b1;
                    edit_idx = pos_m1[IDX_W-1:0];
                end
            end
            KIND_DEL_HEAD: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    del_req = 1'b1;
                end
            end
            KIND_DEL_TAIL: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    del_req  = 1'b1;
                    edit_idx = tail;
                end
            end
            KIND_DEL_POS: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else if (position_i == '0 || position_i > count_reg) begin
                    st = ST_BADPOS;
                end else begin
                    del_req  = 1'b1;
                    edit_idx = pos_m1[IDX_W-1:0];
                end
            end
            KIND_DUMP: begin
                if (empty) begin
                    st = ST_EMPTY;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
        if (ins_req && full) begin
            ins_req = 1'b0;
            st      = ST_FULL;
        end
    end

    always_comb begin
        if (ins_req) begin
            count_after = count_reg + 1'b1;
        end else if (del_req) begin
            count_after = count_reg - 1'b1;
        end else begin
            count_after = count_reg;
        end
    end

    always_comb begin
        cmd_o.op    = CELL_HOLD;
        cmd_o.idx   = edit_idx;
        cmd_o.tail  = tail;
        cmd_o.value = value_i;
        if (state_reg == DUMP && out_free) begin
            cmd_o.op = CELL_ROT;
        end else if (accept && ins_req) begin
            cmd_o.op = CELL_INS;
        end else if (accept && del_req) begin
            cmd_o.op = CELL_DEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            dump_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        if (kind_i == KIND_DUMP && !empty) begin
                            state_reg <= DUMP;
                            dump_reg  <= '0;
                        end else begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= st;
                            m_item_reg   <= '0;
                            m_length_reg <= count_after;
                            m_last_reg   <= 1'b1;
                            count_reg    <= count_after;
                        end
                    end
                end
                DUMP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ST_OK;
                        m_item_reg   <= head_i;
                        m_length_reg <= count_reg;
                        m_last_reg   <= (dump_reg == tail);
                        dump_reg     <= dump_reg + 1'b1;
                        if (dump_reg == tail) begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign status_o = m_status_reg;
    assign item_o   = m_item_reg;
    assign length_o = m_length_reg;
    assign last_o   = m_last_reg;

endmodule

// ===== hw/rtl/positional_circular_list_top.sv =====
// Edits (append, insert, delete): one word per cycle while output is free; result word
// registered in the cycle after accept. Dump of N values: accept enters DUMP, loading one
// result per cycle from the head cell while output is free, as the chain rotates one cell;
// next request accepted after the last is loaded. Empty dump or any edit: one result word.
// Reset (aresetn low, synchronous): length cleared, output empty; cell contents not cleared.
module positional_circular_list_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // item[31:0], length[37:32], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import pcl_pkg::*;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] item;
    logic [CNT_W-1:0]         length;

    pcl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .kind_i     (s_tuser),
        .position_i (s_tdata[POS_W-1:0]),
        .value_i    (s_tdata[POS_W+DATA_W-1:POS_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status_o   (m_tuser),
        .item_o     (item),
        .length_o   (length),
        .last_o     (m_tlast),
        .head_i     (cell_data[0]),
        .cmd_o      (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;

        if (i == 0) begin : g_first
            assign left = cell_data[0];
        end else begin : g_left
            assign left = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right = cell_data[i];
        end else begin : g_right
            assign right = cell_data[i+1];
        end

        pcl_cell u_cell (
            .aclk    (aclk),
            .slot_i  (IDX_W'(i)),
            .cmd_i   (cmd),
            .left_i  (left),
            .right_i (right),
            .head_i  (cell_data[0]),
            .data_o  (cell_data[i])
        );
    end

    assign m_tdata = {2'b00, length, item};

endmodule
